[sv/midi_receive_parser_assert.svh]
// Assertion macros for the MIDI receive parser.
// Included by the top level; no other dependencies.
`ifndef MIDI_RECEIVE_PARSER_ASSERT_SVH
`define MIDI_RECEIVE_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MRP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mrp_pkg.sv]
// Types and constants shared by the MIDI receive parser modules.
// No dependencies.
`default_nettype none
package mrp_pkg;

    localparam logic [1:0] KIND_CHAN = 2'd0;
    localparam logic [1:0] KIND_CMD  = 2'd1;
    localparam logic [1:0] KIND_SET  = 2'd2;

    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_POLY_AT   = 4'hA;
    localparam logic [3:0] NIB_CC        = 4'hB;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT   = 4'hD;
    localparam logic [3:0] NIB_PITCH     = 4'hE;
    localparam logic [3:0] NIB_SYSTEM    = 4'hF;

    localparam logic [7:0] SYS_SELECT    = 8'hF3;
    localparam logic [7:0] SYS_SETTING   = 8'hF4;
    localparam logic [7:0] SYS_PREV      = 8'hF9;
    localparam logic [7:0] SYS_PAUSE     = 8'hFD;
    localparam logic [7:0] SYS_CODE_BASE = 8'hF6;

    localparam logic [7:0] CC_NRPN_MSB   = 8'd99;
    localparam logic [7:0] CC_NRPN_LSB   = 8'd98;
    localparam logic [7:0] CC_DATA_MSB   = 8'd6;
    localparam logic [7:0] CC_DATA_LSB   = 8'd38;
    localparam logic [7:0] NRPN_MSB_VAL  = 8'd96;
    localparam logic [7:0] NRPN_LSB_VAL  = 8'd101;

    localparam logic [2:0] CODE_VOLUME   = 3'd2;

    localparam logic [1:0] LEN_TWO       = 2'd2;
    localparam logic [1:0] LEN_THREE     = 2'd3;

    localparam logic [1:0] NRPN_IDLE     = 2'd0;
    localparam logic [1:0] NRPN_ADDR_MSB = 2'd1;
    localparam logic [1:0] NRPN_ADDR_LSB = 2'd2;
    localparam logic [1:0] NRPN_ARMED    = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] status;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [1:0] len;
        logic [2:0] code;
        logic [7:0] value;
        logic [1:0] sel;
    } event_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] status;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [1:0] len;
        logic [2:0] code;
        logic [7:0] value;
        logic [1:0] sel;
        logic       table_write;
        logic [7:0] table_index;
        logic [7:0] table_value;
    } result_t;

endpackage
`default_nettype wire

[sv/mrp_front.sv]
// Front end: pending byte buffer, running status and message classification.
// Depends on mrp_pkg.
`default_nettype none
module mrp_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     rx_byte,
    output mrp_pkg::event_t     ev,
    output logic                ev_valid
);

    logic [7:0] pend0_reg, pend1_reg, pend2_reg;
    logic [7:0] pend0_next, pend1_next, pend2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [7:0] last_reg, last_next;

    logic [1:0] cnt1;
    logic       rs;
    logic [7:0] cmd;
    logic [2:0] avail;
    logic [7:0] d1, d2;
    logic       clr;

    always_comb begin
        pend0_next = (cnt_reg == 2'd0) ? rx_byte : pend0_reg;
        pend1_next = (cnt_reg == 2'd1) ? rx_byte : pend1_reg;
        pend2_next = (cnt_reg == 2'd2) ? rx_byte : pend2_reg;
        cnt1       = cnt_reg + 2'd1;
        rs         = ~pend0_next[7];
        cmd        = rs ? last_reg : pend0_next;
        last_next  = (cmd[7:4] != mrp_pkg::NIB_SYSTEM) ? cmd : last_reg;
        avail      = {2'b00, rs} + {1'b0, cnt1};
        d1         = rs ? pend0_next : pend1_next;
        d2         = rs ? pend1_next : pend2_next;
        clr        = 1'b0;
        ev_valid   = 1'b0;
        ev         = '0;
        case (cmd[7:4])
            mrp_pkg::NIB_NOTE_OFF, mrp_pkg::NIB_NOTE_ON, mrp_pkg::NIB_POLY_AT,
            mrp_pkg::NIB_PITCH, mrp_pkg::NIB_CC: begin
                if (avail >= 3'd3) begin
                    clr       = 1'b1;
                    ev_valid  = 1'b1;
                    ev.kind   = mrp_pkg::KIND_CHAN;
                    ev.status = cmd;
                    ev.d1     = d1;
                    ev.d2     = d2;
                    ev.len    = mrp_pkg::LEN_THREE;
                end
            end
            mrp_pkg::NIB_PROGRAM, mrp_pkg::NIB_CHAN_AT: begin
                if (avail >= 3'd2) begin
                    clr       = 1'b1;
                    ev_valid  = 1'b1;
                    ev.kind   = mrp_pkg::KIND_CHAN;
                    ev.status = cmd;
                    ev.d1     = d1;
                    ev.len    = mrp_pkg::LEN_TWO;
                end
            end
            mrp_pkg::NIB_SYSTEM: begin
                if (cmd == mrp_pkg::SYS_SELECT || cmd == mrp_pkg::SYS_SETTING) begin
                    if (cnt1 == 2'd3) begin
                        clr = 1'b1;
                        if (cmd == mrp_pkg::SYS_SELECT) begin
                            if (pend1_next <= 8'd1) begin
                                ev_valid = 1'b1;
                                ev.kind  = mrp_pkg::KIND_CMD;
                                ev.code  = pend1_next[2:0];
                                ev.value = pend2_next;
                            end
                        end else if (pend1_next == 8'd0) begin
                            ev_valid = 1'b1;
                            ev.kind  = mrp_pkg::KIND_CMD;
                            ev.code  = mrp_pkg::CODE_VOLUME;
                            ev.value = pend2_next;
                        end else if (pend1_next <= 8'd3) begin
                            ev_valid = 1'b1;
                            ev.kind  = mrp_pkg::KIND_SET;
                            ev.sel   = pend1_next[1:0] - 2'd1;
                            ev.value = pend2_next;
                        end
                    end
                end else begin
                    clr = 1'b1;
                    if (cmd >= mrp_pkg::SYS_PREV && cmd <= mrp_pkg::SYS_PAUSE) begin
                        ev_valid = 1'b1;
                        ev.kind  = mrp_pkg::KIND_CMD;
                        ev.code  = 3'(cmd - mrp_pkg::SYS_CODE_BASE);
                    end
                end
            end
            default: begin
                clr = 1'b1;
            end
        endcase
        cnt_next = clr ? 2'd0 : cnt1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            last_reg <= 8'd0;
        end else if (accept) begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            pend2_reg <= pend2_next;
        end
    end

endmodule
`default_nettype wire

[sv/mrp_queue.sv]
// Two-entry queue of classified events between front and back end.
// Depends on mrp_pkg.
`default_nettype none
module mrp_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire mrp_pkg::event_t push_data,
    input  wire logic            pop,
    output logic                 full,
    output logic                 valid,
    output mrp_pkg::event_t      head
);

    mrp_pkg::event_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[sv/mrp_back.sv]
// Back end: NRPN tracking, result formatting and the output register.
// Depends on mrp_pkg.
`default_nettype none
module mrp_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire mrp_pkg::event_t q_head,
    output logic                 q_pop,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output mrp_pkg::result_t     out_result
);

    logic [1:0]       stage_reg, stage_next;
    logic [7:0]       id_reg, id_next;
    logic             valid_reg;
    mrp_pkg::result_t res_reg, res_next;
    logic             is_cc;

    assign q_pop      = q_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = res_reg;

    always_comb begin
        stage_next           = stage_reg;
        id_next              = id_reg;
        res_next             = '0;
        res_next.kind        = q_head.kind;
        res_next.status      = q_head.status;
        res_next.first_data  = q_head.d1;
        res_next.second_data = q_head.d2;
        res_next.len         = q_head.len;
        res_next.code        = q_head.code;
        res_next.value       = q_head.value;
        res_next.sel         = q_head.sel;
        is_cc = (q_head.kind == mrp_pkg::KIND_CHAN) &&
                (q_head.status[7:4] == mrp_pkg::NIB_CC);
        if (is_cc) begin
            if (q_head.d1 == mrp_pkg::CC_NRPN_MSB) begin
                if (q_head.d2 == mrp_pkg::NRPN_MSB_VAL) begin
                    stage_next = mrp_pkg::NRPN_ADDR_MSB;
                end
            end else if (q_head.d1 == mrp_pkg::CC_NRPN_LSB) begin
                if (stage_reg == mrp_pkg::NRPN_ADDR_MSB &&
                    q_head.d2 == mrp_pkg::NRPN_LSB_VAL) begin
                    stage_next = mrp_pkg::NRPN_ADDR_LSB;
                end
            end else if (q_head.d1 == mrp_pkg::CC_DATA_MSB) begin
                if (stage_reg == mrp_pkg::NRPN_ADDR_LSB) begin
                    stage_next = mrp_pkg::NRPN_ARMED;
                    id_next    = q_head.d2;
                end
            end else if (q_head.d1 == mrp_pkg::CC_DATA_LSB) begin
                if (stage_reg == mrp_pkg::NRPN_ARMED) begin
                    res_next.table_write = 1'b1;
                    res_next.table_index = id_reg;
                    res_next.table_value = q_head.d2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            stage_reg <= mrp_pkg::NRPN_IDLE;
        end else begin
            if (q_pop) begin
                valid_reg <= 1'b1;
                stage_reg <= stage_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            res_reg <= res_next;
            id_reg  <= id_next;
        end
    end

endmodule
`default_nettype wire

[sv/midi_receive_parser.sv]
// MIDI receive parser. Takes one serial MIDI byte per transfer on the s_ side and
// gives forwarded channel messages (running status filled in), remote commands,
// setting updates and NRPN table writes on the m_ side. The edge that accepts a
// message's last byte writes its event into the queue, from which it reaches
// m_tvalid through the output register. Sustained rate is one byte per cycle; a
// two-entry event queue and the output register absorb stalls on the m_ side,
// and s_tready drops only when that queue is full.
// Depends on mrp_pkg, mrp_front, mrp_queue, mrp_back and the assertion header.
`default_nettype none
`include "midi_receive_parser_assert.svh"
module midi_receive_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] msg_status, [15:8] msg_first_data, [23:16] msg_second_data,
    // [25:24] msg_length, [28:26] command_code, [36:29] value_byte,
    // [38:37] setting_select, [39] table_write, [47:40] table_index,
    // [55:48] table_value
    output logic [55:0]      m_tdata,
    output logic [1:0]       m_tuser   // [1:0] result_kind
);

    logic             s_accept;
    logic             ev_valid;
    mrp_pkg::event_t  ev;
    logic             q_full, q_valid, q_pop;
    mrp_pkg::event_t  q_head;
    mrp_pkg::result_t res;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    mrp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_accept),
        .rx_byte  (s_tdata),
        .ev       (ev),
        .ev_valid (ev_valid)
    );

    mrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept && ev_valid),
        .push_data (ev),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    mrp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {res.table_value, res.table_index, res.table_write, res.sel,
                      res.value, res.code, res.len, res.second_data,
                      res.first_data, res.status};

    `MRP_ASSERT_IMPL(a_chan_len, aclk, aresetn, m_tvalid && m_tuser == mrp_pkg::KIND_CHAN, m_tdata[25:24] == mrp_pkg::LEN_TWO || m_tdata[25:24] == mrp_pkg::LEN_THREE, "forwarded message with bad length")
    `MRP_ASSERT_IMPL(a_table_cc, aclk, aresetn, m_tvalid && m_tdata[39], m_tuser == mrp_pkg::KIND_CHAN && m_tdata[7:4] == mrp_pkg::NIB_CC && m_tdata[15:8] == mrp_pkg::CC_DATA_LSB, "table write not on control change 38")
    `MRP_ASSERT_NEXT(a_full_hold, aclk, aresetn, q_full && !q_pop, !s_tready, "queue full but input still ready")

endmodule
`default_nettype wire
